### sv/ehist_pkg.sv
package ehist_pkg;

  // fixed field widths
  localparam int BIN_W      = 14;
  localparam int CH_W       = 4;
  localparam int ENA_W      = 16;
  localparam int OUT_CNT_W  = 32;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // enabled channels beyond this count are treated as off
  localparam int NUM_CHANNELS = 16;

  localparam int DEF_BIN_BITS   = 14;
  localparam int DEF_COUNT_BITS = 32;

  // command codes
  localparam logic CMD_HIT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_CUTOFF = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  localparam logic [BIN_W-1:0] CUTOFF_RST = '0;
  localparam logic [ENA_W-1:0] ENABLE_RST = ENA_W'(1);

  typedef struct packed {
    logic [BIN_W-1:0] min_bin;
    logic [ENA_W-1:0] channel_enable;
  } ehist_cfg_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } ehist_state_t;

endpackage

### sv/ehist_mem.sv
module ehist_mem import ehist_pkg::*; #(
  parameter int AW = DEF_BIN_BITS,
  parameter int DW = DEF_COUNT_BITS
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // read-before-write on a shared address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/ehist_regs.sv
module ehist_regs import ehist_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output ehist_cfg_t        cfg
);

  logic [BIN_W-1:0] cutoff_r;
  logic [ENA_W-1:0] enable_r;
  logic             wr_en;
  logic             idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CUTOFF_RST;
      enable_r <= ENABLE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_CUTOFF: cutoff_r <= pwdata[BIN_W-1:0];
        REG_ENABLE: enable_r <= pwdata[ENA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CUTOFF: prdata = APB_DW'(cutoff_r);
      REG_ENABLE: prdata = APB_DW'(enable_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.min_bin        = cutoff_r;
  assign cfg.channel_enable = enable_r;

endmodule

### sv/ehist_clear.sv
module ehist_clear import ehist_pkg::*; #(
  parameter int AW = DEF_BIN_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          busy,
  output logic [AW-1:0] addr
);

  ehist_state_t  state_r, state_nxt;
  logic [AW-1:0] addr_r;
  logic          last;

  assign last = (addr_r == {AW{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        addr_r <= addr_r + AW'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (last) state_nxt = ST_RUN;
      ST_RUN:   state_nxt = ST_RUN;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_CLEAR: busy = 1'b1;
      ST_RUN:   busy = 1'b0;
      default:  busy = 1'b1;
    endcase
  end

  assign addr = addr_r;

endmodule

### sv/energy_histogram_accumulator.sv
// Timing: the count memory read and the update stage load at the input transfer edge; the result
//   goes into the output register when the stage advances, which waits for a free output register.
// Throughput: one item per cycle unless the output stalls; the count memory has a read port and a
//   write port; reads and write-backs overlap, with a write-data bypass for back-to-back hits on one bin.
// Reset (rst_n low, synchronous): config goes to cutoff 0 / channel 0 enabled, highest bin 0,
//   then a clearing pass zeroes all 2^BIN_BITS bins, one per cycle; in_ready stays low for it.
module energy_histogram_accumulator import ehist_pkg::*; #(
  parameter int BIN_BITS   = DEF_BIN_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [CH_W-1:0]      in_source_channel,
  input  logic [BIN_W-1:0]     in_bin,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_CNT_W-1:0] out_bin_count,
  output logic [BIN_W-1:0]     out_highest_bin,
  output logic                 out_accepted,
  // register port
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [APB_AW-1:0]    cfg_paddr,
  input  logic [APB_DW-1:0]    cfg_pwdata,
  output logic [APB_DW-1:0]    cfg_prdata,
  output logic                 cfg_pready
);

  localparam int AW = BIN_BITS;
  localparam int CW = COUNT_BITS;

  ehist_cfg_t cfg;

  // clear sequencer
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic [CW-1:0] mem_rdata;

  // update stage: the item whose count is coming out of the memory
  logic             s1_v_r;
  logic             s1_cmd_r;
  logic [CH_W-1:0]  s1_ch_r;
  logic [BIN_W-1:0] s1_bin_r;
  logic [AW-1:0]    s1_addr;

  // bypass of the last write
  logic          fwd_v_r;
  logic [AW-1:0] fwd_addr_r;
  logic [CW-1:0] fwd_data_r;

  // output register
  logic                 out_v_r;
  logic [OUT_CNT_W-1:0] out_cnt_r;
  logic [BIN_W-1:0]     out_max_r;
  logic                 out_acc_r;

  logic [BIN_W-1:0] max_r, max_nxt;

  logic          in_xfer;
  logic          adv;
  logic          in_range;
  logic          ch_on;
  logic          hit_ok;
  logic [CW-1:0] cur_cnt;
  logic [CW-1:0] inc_cnt;
  logic [CW-1:0] res_cnt;

  ehist_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ehist_clear #(.AW(AW)) u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (clearing),
    .addr  (clr_addr)
  );

  ehist_mem #(.AW(AW), .DW(CW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_xfer),
    .raddr (AW'(in_bin)),
    .rdata (mem_rdata)
  );

  // Stage advances when the output register is free or drains this cycle.
  assign adv      = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !clearing && (!s1_v_r || adv);
  assign in_xfer  = in_valid && in_ready;

  assign s1_addr  = AW'(s1_bin_r);
  assign in_range = ((32'(s1_bin_r) >> BIN_BITS) == 32'd0);
  assign ch_on    = (int'(s1_ch_r) < NUM_CHANNELS) && cfg.channel_enable[s1_ch_r];
  assign hit_ok   = (s1_cmd_r == CMD_HIT) && in_range && ch_on
                    && (s1_bin_r >= cfg.min_bin);

  // The read ran in the same cycle as the previous write; pick up that write.
  always_comb begin
    if (!in_range) begin
      cur_cnt = '0;
    end else if (fwd_v_r && (fwd_addr_r == s1_addr)) begin
      cur_cnt = fwd_data_r;
    end else begin
      cur_cnt = mem_rdata;
    end
  end

  // saturating increment
  assign inc_cnt = (cur_cnt == {CW{1'b1}}) ? cur_cnt : cur_cnt + CW'(1);
  assign res_cnt = hit_ok ? inc_cnt : cur_cnt;

  assign max_nxt = (hit_ok && (s1_bin_r > max_r)) ? s1_bin_r : max_r;

  // write port: clearing pass first, then hit updates
  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = adv && hit_ok;
      mem_waddr = s1_addr;
      mem_wdata = inc_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
      out_v_r <= 1'b0;
      max_r   <= '0;
    end else begin
      if (in_xfer) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (mem_we) begin
        fwd_v_r <= 1'b1;
      end
      if (adv) begin
        out_v_r <= 1'b1;
        max_r   <= max_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r <= in_cmd;
      s1_ch_r  <= in_source_channel;
      s1_bin_r <= in_bin;
    end
    if (mem_we) begin
      fwd_addr_r <= mem_waddr;
      fwd_data_r <= mem_wdata;
    end
    if (adv) begin
      out_cnt_r <= OUT_CNT_W'(res_cnt);
      out_max_r <= max_nxt;
      out_acc_r <= hit_ok;
    end
  end

  assign out_valid       = out_v_r;
  assign out_bin_count   = out_cnt_r;
  assign out_highest_bin = out_max_r;
  assign out_accepted    = out_acc_r;

`ifndef SYNTHESIS
  // no item enters while the clearing pass owns the write port
  a_no_xfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_xfer)
    else $error("input transfer during clearing pass");

  // hit writes come only from a valid hit in the update stage
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && !clearing) |-> (s1_v_r && s1_cmd_r == CMD_HIT && adv))
    else $error("count write without a hit");

  // the highest bin only grows between resets
  a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (max_r >= $past(max_r)))
    else $error("highest bin decreased");

  // an accepted hit reaches the output flagged, with the highest bin covering it
  a_accept_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && hit_ok) |=> (out_v_r && out_acc_r && (out_max_r >= $past(s1_bin_r))))
    else $error("accepted hit lost in output register");
`endif

endmodule

### tb/sv/ehist_checker.sv
module ehist_checker import ehist_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [CH_W-1:0]      in_source_channel,
  input  logic [BIN_W-1:0]     in_bin,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [OUT_CNT_W-1:0] out_bin_count,
  input  logic [BIN_W-1:0]     out_highest_bin,
  input  logic                 out_accepted,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [APB_AW-1:0]    cfg_paddr,
  input  logic [APB_DW-1:0]    cfg_pwdata,
  input  logic                 cfg_pready,
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBINS = 1 << DEF_BIN_BITS;
  localparam logic [DEF_COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    logic [BIN_W-1:0]     highest;
    logic                 accepted;
  } spectrum_result_t;

  logic [DEF_COUNT_BITS-1:0] bin_counts [NBINS];
  logic [BIN_W-1:0]          peak_bin;
  ehist_cfg_t                cfg;
  spectrum_result_t          spectrum_results [$];
  int                        errs = 0;
  int                        n_waiting = 0;

  assign mismatches  = errs;
  assign outstanding = n_waiting;

  function automatic logic channel_enabled(input logic [CH_W-1:0] ch);
    if (ch >= NUM_CHANNELS || ch >= ENA_W) return 1'b0;
    return cfg.channel_enable[ch];
  endfunction

  // applies one hit or read to the spectrum and returns what the block should report
  function automatic spectrum_result_t bin_event(input logic cmd, input logic [CH_W-1:0] ch,
                                                 input logic [BIN_W-1:0] b);
    spectrum_result_t          r;
    logic [DEF_COUNT_BITS-1:0] count;
    logic                      in_store;
    in_store   = int'(b) < NBINS;
    count      = in_store ? bin_counts[b] : '0;
    r.accepted = 1'b0;
    if (cmd == CMD_HIT && in_store && channel_enabled(ch) && b >= cfg.min_bin) begin
      if (count != COUNT_MAX) count = count + 1'b1;
      bin_counts[b] = count;
      if (b > peak_bin) peak_bin = b;
      r.accepted = 1'b1;
    end
    r.count   = count[OUT_CNT_W-1:0];
    r.highest = peak_bin;
    return r;
  endfunction

  always @(posedge clk) begin
    spectrum_result_t want;
    if (!rst_n) begin
      foreach (bin_counts[i]) bin_counts[i] = '0;
      peak_bin           = '0;
      cfg.min_bin        = CUTOFF_RST;
      cfg.channel_enable = ENABLE_RST;
      spectrum_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[2])
          REG_CUTOFF: cfg.min_bin        = cfg_pwdata[BIN_W-1:0];
          REG_ENABLE: cfg.channel_enable = cfg_pwdata[ENA_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (spectrum_results.size() == 0) begin
          errs++;
          $display("%0t: unexpected result count %0d highest %0d accepted %b",
                   $time, out_bin_count, out_highest_bin, out_accepted);
        end else begin
          want = spectrum_results.pop_front();
          if (out_bin_count !== want.count) begin
            errs++;
            $display("%0t: bin_count expected %0d got %0d", $time, want.count, out_bin_count);
          end
          if (out_highest_bin !== want.highest) begin
            errs++;
            $display("%0t: highest_bin expected %0d got %0d",
                     $time, want.highest, out_highest_bin);
          end
          if (out_accepted !== want.accepted) begin
            errs++;
            $display("%0t: accepted expected %b got %b", $time, want.accepted, out_accepted);
          end
        end
      end
      if (in_valid && in_ready)
        spectrum_results.insert(spectrum_results.size(),
                                bin_event(in_cmd, in_source_channel, in_bin));
    end
    n_waiting = spectrum_results.size();
  end

endmodule

### tb/sv/testbench.sv
module testbench import ehist_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // register byte addresses: index 4*i
  localparam logic [APB_AW-1:0] ADDR_CUTOFF = {REG_CUTOFF, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_ENABLE = {REG_ENABLE, 2'b00};

  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 184;
  localparam int LONG_HOLD       = 300;   // receiver hold-off, long enough to back up the pipe
  localparam int BURST_ITEMS     = 60;
  localparam int SETTLE_CYCLES   = 4;
  // the clearing pass runs with no transfers; allow well over its length
  localparam int WATCHDOG_LIMIT  = 60000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_cmd;
  logic [CH_W-1:0]      in_source_channel;
  logic [BIN_W-1:0]     in_bin;
  logic                 out_valid;
  logic                 out_ready;
  logic [OUT_CNT_W-1:0] out_bin_count;
  logic [BIN_W-1:0]     out_highest_bin;
  logic                 out_accepted;
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [APB_AW-1:0]    cfg_paddr;
  logic [APB_DW-1:0]    cfg_pwdata;
  logic [APB_DW-1:0]    cfg_prdata;
  logic                 cfg_pready;

  int mismatches;
  int outstanding;

  // shared between the sender and the result sink
  int stall_req  = 0;   // bumped by the sender to ask for one long hold-off
  int burst_left = 0;   // transfers still to go with no gaps

  // sender's view of the current settings, used to aim bins
  logic [BIN_W-1:0] cur_cutoff = CUTOFF_RST;
  logic [ENA_W-1:0] cur_enable = ENABLE_RST;
  logic [BIN_W-1:0] hot_base   = '0;
  logic [BIN_W-1:0] last_bin   = '0;

  always #1 clk = ~clk;

  energy_histogram_accumulator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_source_channel (in_source_channel),
    .in_bin            (in_bin),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bin_count     (out_bin_count),
    .out_highest_bin   (out_highest_bin),
    .out_accepted      (out_accepted),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  ehist_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_source_channel (in_source_channel),
    .in_bin            (in_bin),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bin_count     (out_bin_count),
    .out_highest_bin   (out_highest_bin),
    .out_accepted      (out_accepted),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_pready        (cfg_pready),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  // mostly short gaps, one in ten long
  function automatic int idle_gap();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 40)) : int'($urandom_range(1, 3));
  endfunction

  // Called at a falling edge. Holds valid and payload until the transfer, then
  // returns at the next falling edge, possibly after an idle gap.
  task automatic send_item(input logic cmd, input logic [CH_W-1:0] ch,
                           input logic [BIN_W-1:0] b);
    int gap;
    in_valid          <= 1'b1;
    in_cmd            <= cmd;
    in_source_channel <= ch;
    in_bin            <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 99) < 65) ? 0 : idle_gap();
      // now and then a stretch of back-to-back transfers
      if ($urandom_range(0, 199) == 0) burst_left = 40;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every result is back, then wait SETTLE_CYCLES so the
  // pipe is empty before any register write.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // setup phase, access phase, then an idle gap so calls can chain
  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [BIN_W-1:0] cutoff, input logic [ENA_W-1:0] enable);
    write_reg(ADDR_CUTOFF, APB_DW'(cutoff));
    write_reg(ADDR_ENABLE, APB_DW'(enable));
    cur_cutoff = cutoff;
    cur_enable = enable;
  endtask

  // Random hit or read. Bins cluster on a small hot set and around the cutoff
  // so counts build up and the cutoff edge gets exercised; repeats of the
  // previous bin hit the back-to-back bypass.
  task automatic send_random_item();
    logic             cmd;
    logic [CH_W-1:0]  ch;
    logic [BIN_W-1:0] b;
    int               r;
    cmd = ($urandom_range(0, 99) < 30) ? CMD_READ : CMD_HIT;
    ch  = CH_W'($urandom());
    // lean toward enabled channels, or most hits die on the mask
    if ($urandom_range(0, 99) < 70) begin
      for (int k = 0; k < 8; k++)
        if (!cur_enable[ch]) ch = CH_W'($urandom());
    end
    r = $urandom_range(0, 99);
    if (r < 45)
      b = hot_base + BIN_W'($urandom_range(0, 15));
    else if (r < 60)
      b = last_bin;
    else if (r < 75)
      b = cur_cutoff + BIN_W'($urandom_range(0, 8)) - BIN_W'(4);
    else if (r < 90)
      b = BIN_W'($urandom());
    else
      b = $urandom_range(0, 1) ? '1 : '0;
    last_bin = b;
    send_item(cmd, ch, b);
  endtask

  // Result sink: random ready with calm stretches, plus a long hold-off each
  // time the sender asks for one.
  initial begin : result_sink
    int hold;
    int calm;
    int stalls_done;
    out_ready   = 1'b0;
    hold        = 0;
    calm        = 0;
    stalls_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stalls_done != stall_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        stalls_done++;
      end else if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if (calm > 0)
          calm--;
        else if ($urandom_range(0, 199) == 0)
          calm = 150;
        else if ($urandom_range(0, 99) < 30)
          hold = idle_gap();
      end
    end
  end

  // Watchdog: any transfer on either channel or a register write resets it.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_cmd            = CMD_HIT;
    in_source_channel = '0;
    in_bin            = '0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // block clears every bin after reset with in_ready low
    while (!in_ready) @(negedge clk);

    // --- directed, reset settings: cutoff 0, only channel 0 on ---
    send_item(CMD_READ, 0, 0);          // freshly cleared bin
    send_item(CMD_HIT, 0, 0);           // lowest bin
    send_item(CMD_HIT, 0, '1);          // top bin, becomes highest
    send_item(CMD_READ, '1, '1);        // channel is don't-care on a read
    send_item(CMD_HIT, 1, 5);           // masked channel
    send_item(CMD_HIT, '1, 100);        // top channel, masked
    repeat (4) send_item(CMD_HIT, 0, 7);  // repeated hits on one bin
    send_item(CMD_READ, 0, 7);
    finish_phase();

    // cutoff edge with every channel on
    set_config(100, '1);
    send_item(CMD_HIT, '1, 99);         // one below cutoff
    send_item(CMD_HIT, '1, 100);        // exactly at cutoff
    send_item(CMD_HIT, 3, '1);
    send_item(CMD_READ, 0, 100);
    send_item(CMD_HIT, 0, 0);           // rejected, still reports the old count
    finish_phase();

    // cutoff at its top, single high channel
    set_config('1, 16'h8000);
    send_item(CMD_HIT, '1, '1 - 1'b1);
    send_item(CMD_HIT, '1, '1);
    send_item(CMD_HIT, 14, '1);
    send_item(CMD_READ, 0, '1);
    finish_phase();
    // count saturation needs 2^32 hits on one bin; the checker models it but
    // no run this short can get there

    // --- random phases ---
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       set_config('0, '1);
        1:       set_config(BIN_W'($urandom_range(1, 16382)), ENA_W'($urandom()));
        2:       set_config('1, '1);
        3:       set_config('0, '0);
        4:       set_config(BIN_W'($urandom_range(0, 300)), ENA_W'($urandom()));
        5:       set_config(BIN_W'($urandom()), 16'h8001);
        default: set_config(BIN_W'($urandom()), ENA_W'($urandom()));
      endcase
      hot_base = ($urandom_range(0, 3) == 0) ? BIN_W'($urandom())
                                             : cur_cutoff + BIN_W'($urandom_range(0, 64));
      last_bin = hot_base;
      // back up the pipe: receiver stalls while the sender keeps offering
      if (p == 1 || p == 4) begin
        stall_req++;
        burst_left = BURST_ITEMS;
      end
      repeat (ITEMS_PER_PHASE) send_random_item();
      finish_phase();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
